### hdl/ple_pkg.sv
// Shared constants, codes and types for the positional list engine.
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

  localparam int LIST_DEPTH  = 16;
  localparam int MAX_RESULTS = 16;

  localparam int DATA_W = 32;
  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  // common width for position / count compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_BEFORE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_AFTER  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd5;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

  // What a cell loads at the next edge.
  typedef enum logic [2:0] {
    CM_HOLD,   // keep own value
    CM_LOAD,   // take the operand value
    CM_LEFT,   // take left neighbor (insert shift)
    CM_RIGHT,  // take right neighbor (delete / rotate shift)
    CM_HEAD    // take the head value (rotate wrap)
  } cell_mode_t;

endpackage
`default_nettype wire

### hdl/positional_list_engine_unit.sv
// Top level of the positional list engine: cell row, control and result registers.
// A non-readout word is on the result ports in the cycle after its accept edge;
// a readout first moves to the read state, then issues one word per cycle from the head.
// Throughput: one item per cycle, except readout: busy holds while the row rotates once,
// so no new word is accepted until the last element has been issued.
// No receiver stall. Synchronous reset (rst_n low) empties the list, clears busy, out_valid.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_engine_unit
  import ple_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [ACT_W-1:0]  in_action,
  input  wire logic        [POS_W-1:0]  in_position,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic             [STAT_W-1:0] out_status,
  output logic             [POS_W-1:0]  out_found_position,
  output logic signed      [DATA_W-1:0] out_element,
  output logic             [LEN_W-1:0]  out_length,
  output logic                          out_last
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;

  logic              valid_r, valid_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [POS_W-1:0]  fpos_r, fpos_nxt;
  logic [DATA_W-1:0] elem_r, elem_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              last_r, last_nxt;

  // cell row
  cell_mode_t        cell_mode [LIST_DEPTH];
  logic [DATA_W-1:0] cell_data [LIST_DEPTH];
  logic              cell_hit  [LIST_DEPTH];

  logic              accept;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  ins_idx;
  logic              full;
  logic              pos_bad;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [CNT_W-1:0]  rd_next;

  assign busy    = (state_r == ST_READ);
  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (int'(count_r) >= LIST_DEPTH);
  // insert before/after and delete all need 1..length
  assign pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign rd_next = CNT_W'(rd_idx_r) + CNT_W'(1);

  // Row of cells; each sees its neighbors, the head value and the operand.
  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    ple_cell u_cell (
      .clk       (clk),
      .mode      (cell_mode[g]),
      .load_val  (in_value),
      .left_val  (cell_data[(g == 0) ? 0 : g - 1]),
      .right_val (cell_data[(g == LIST_DEPTH - 1) ? g : g + 1]),
      .head_val  (cell_data[0]),
      .key       (in_value),
      .data      (cell_data[g]),
      .hit       (cell_hit[g])
    );
  end

  // Search: lowest live cell that matches the key wins.
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (cell_hit[i] && (CNT_W'(i) < count_r)) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
    end
  end

  // Slot that an insert lands in.
  always_comb begin
    case (in_action)
      ACT_HEAD:   ins_idx = '0;
      ACT_TAIL:   ins_idx = cnt_ext;
      ACT_BEFORE: ins_idx = pos_ext - CMP_W'(1);
      default:    ins_idx = pos_ext;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    valid_nxt  = 1'b0;
    status_nxt = STAT_OK;
    fpos_nxt   = '0;
    elem_nxt   = '0;
    len_nxt    = LEN_W'(count_r);
    last_nxt   = 1'b1;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      cell_mode[i] = CM_HOLD;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          valid_nxt = 1'b1;
          case (in_action)
            ACT_HEAD, ACT_TAIL, ACT_BEFORE, ACT_AFTER: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else if ((in_action inside {ACT_BEFORE, ACT_AFTER}) && pos_bad) begin
                status_nxt = STAT_BADPOS;
              end else begin
                // hold below the slot, load the slot, shift the rest right
                for (int i = 0; i < LIST_DEPTH; i++) begin
                  if (CMP_W'(i) == ins_idx) begin
                    cell_mode[i] = CM_LOAD;
                  end else if (CMP_W'(i) > ins_idx) begin
                    cell_mode[i] = CM_LEFT;
                  end
                end
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ACT_DELETE: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (pos_bad) begin
                status_nxt = STAT_BADPOS;
              end else begin
                // close the gap: every cell from the slot on takes its right neighbor
                for (int i = 0; i < LIST_DEPTH; i++) begin
                  if (CMP_W'(i) >= pos_ext - CMP_W'(1)) begin
                    cell_mode[i] = CM_RIGHT;
                  end
                end
                count_nxt = count_r - CNT_W'(1);
              end
            end
            ACT_SEARCH: begin
              if (found) begin
                fpos_nxt = POS_W'(CNT_W'(found_idx) + CNT_W'(1));
              end else begin
                status_nxt = STAT_EMPTY;
              end
            end
            ACT_READ: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                // words come from the rotation; drop this strobe
                valid_nxt  = 1'b0;
                rd_idx_nxt = '0;
                state_nxt  = ST_READ;
              end
            end
            default: begin
              // unused code: report ok, leave the list alone
            end
          endcase
          len_nxt = LEN_W'(count_nxt);
        end
      end

      ST_READ: begin
        // issue the head, then rotate the live part of the row left by one
        valid_nxt = (int'(rd_idx_r) < MAX_RESULTS);
        elem_nxt  = cell_data[0];
        last_nxt  = (rd_next == count_r) || (int'(rd_next) == MAX_RESULTS);
        for (int i = 0; i < LIST_DEPTH; i++) begin
          if (CNT_W'(i + 1) == count_r) begin
            cell_mode[i] = CM_HEAD;
          end else if (CNT_W'(i + 1) < count_r) begin
            cell_mode[i] = CM_RIGHT;
          end
        end
        if (rd_next == count_r) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_idx_nxt = rd_idx_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    status_r <= status_nxt;
    fpos_r   <= fpos_nxt;
    elem_r   <= elem_nxt;
    len_r    <= len_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_found_position = fpos_r;
  assign out_element        = elem_r;
  assign out_length         = len_r;
  assign out_last           = last_r;

endmodule
`default_nettype wire

### hdl/ple_cell.sv
// One storage cell of the list row: holds a value, shifts, compares to the key.
`timescale 1ns / 1ps
`default_nettype none
module ple_cell
  import ple_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_mode_t        mode,
  input  wire logic [DATA_W-1:0] load_val,
  input  wire logic [DATA_W-1:0] left_val,
  input  wire logic [DATA_W-1:0] right_val,
  input  wire logic [DATA_W-1:0] head_val,
  input  wire logic [DATA_W-1:0] key,
  output logic      [DATA_W-1:0] data,
  output logic                   hit
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    case (mode)
      CM_LOAD:  data_nxt = load_val;
      CM_LEFT:  data_nxt = left_val;
      CM_RIGHT: data_nxt = right_val;
      CM_HEAD:  data_nxt = head_val;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign hit  = (data_r == key);

endmodule
`default_nettype wire

### test/positional_list_engine_unit_test.sv
// Self-checking testbench for the positional list engine: directed table, then random words.
`timescale 1ns / 1ps
module positional_list_engine_unit_test;
  import ple_pkg::*;

  // Action code 7 is unused by the block: it must answer with a plain OK word.
  localparam logic [ACT_W-1:0] ACT_SPARE = 3'd7;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 24;    // longest readout plus pipeline slack
  localparam int RANDOM_WORDS   = 37;    // per idling phase

  // One result word as the block should present it.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] element;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } list_word_t;

  // One row of the directed plan. Rows marked typed carry their own expected
  // single result word; the rest are checked against the list predictor.
  typedef struct packed {
    logic [ACT_W-1:0]         act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    logic [4:0]               reps;
    logic                     typed;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         found_position;
    logic [LEN_W-1:0]         length;
  } plan_row_t;

  localparam int PLAN_ROWS = 27;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [ACT_W-1:0]         in_action;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic [POS_W-1:0]         out_found_position;
  logic signed [DATA_W-1:0] out_element;
  logic [LEN_W-1:0]         out_length;
  logic                     out_last;

  // Shadow copy of the list, position 1 at index 0.
  logic signed [DATA_W-1:0] shadow_cells [LIST_DEPTH];
  int                       shadow_count;
  list_word_t               expected_words [$];
  list_word_t               seen_word;
  plan_row_t                plan [PLAN_ROWS];
  int                       fail_count;
  int                       quiet_cycles;
  bit                       draining;

  positional_list_engine_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_element        (out_element),
    .out_length         (out_length),
    .out_last           (out_last)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one operation to the shadow list and queue the words it must cause.
  function automatic void predict_list_op(input logic [ACT_W-1:0] act,
                                          input logic [POS_W-1:0] pos,
                                          input logic signed [DATA_W-1:0] val);
    logic [STAT_W-1:0] st;
    logic [POS_W-1:0]  hit;
    int                slot;
    int                n;
    st   = STAT_OK;
    hit  = '0;
    slot = -1;
    case (act)
      ACT_HEAD, ACT_TAIL, ACT_BEFORE, ACT_AFTER: begin
        // A full list wins over a bad position.
        if (shadow_count >= LIST_DEPTH) st = STAT_FULL;
        else if (act == ACT_HEAD) slot = 0;
        else if (act == ACT_TAIL) slot = shadow_count;
        else if (pos < 1 || pos > shadow_count) st = STAT_BADPOS;
        else slot = (act == ACT_BEFORE) ? pos - 1 : pos;
        if (slot >= 0) begin
          for (int i = shadow_count; i > slot; i--) shadow_cells[i] = shadow_cells[i - 1];
          shadow_cells[slot] = val;
          shadow_count++;
        end
      end
      ACT_DELETE: begin
        if (shadow_count == 0) st = STAT_EMPTY;
        else if (pos < 1 || pos > shadow_count) st = STAT_BADPOS;
        else begin
          for (int i = pos - 1; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
          shadow_count--;
        end
      end
      ACT_SEARCH: begin
        st = STAT_EMPTY;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_cells[i] == val && st != STAT_OK) begin
            st  = STAT_OK;
            hit = POS_W'(i + 1);
          end
        end
      end
      ACT_READ: begin
        if (shadow_count == 0) st = STAT_EMPTY;
        else begin
          n = (shadow_count > MAX_RESULTS) ? MAX_RESULTS : shadow_count;
          for (int i = 0; i < n; i++)
            expected_words.push_back(list_word_t'{STAT_OK, '0, shadow_cells[i],
                                                  LEN_W'(shadow_count), i == n - 1});
          return;
        end
      end
      default: ;
    endcase
    expected_words.push_back(list_word_t'{st, hit, '0, LEN_W'(shadow_count), 1'b1});
  endfunction

  // Drive one word from a falling edge, hold it until the block takes it, then
  // predict at the next falling edge, before the result side samples any result of it.
  task automatic issue_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_action   = act;
    in_position = pos;
    in_value    = val;
    start       = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    predict_list_op(act, pos, val);
  endtask

  // Spread the insert share of the drain mix over all four insert actions.
  function automatic logic [ACT_W-1:0] ACT_ACT_PICK(input int r);
    case (r % 4)
      0: return ACT_HEAD;
      1: return ACT_TAIL;
      2: return ACT_BEFORE;
      default: return ACT_AFTER;
    endcase
  endfunction

  // Pick a random word from the shadow state. Alternate between filling toward
  // a full list and draining toward an empty one so both ends get exercised.
  task automatic pick_random_word(output logic [ACT_W-1:0] act, output logic [POS_W-1:0] pos,
                                  output logic signed [DATA_W-1:0] val);
    int r;
    r = $urandom_range(99);
    if (shadow_count == 0) draining = 1'b0;
    else if (shadow_count == LIST_DEPTH && $urandom_range(3) == 0) draining = 1'b1;
    else if ($urandom_range(99) < 3) draining = ~draining;

    if (!draining) begin
      if (r < 30) act = ACT_TAIL;
      else if (r < 45) act = ACT_HEAD;
      else if (r < 60) act = ACT_BEFORE;
      else if (r < 75) act = ACT_AFTER;
      else if (r < 82) act = ACT_DELETE;
      else if (r < 90) act = ACT_SEARCH;
      else if (r < 96) act = ACT_READ;
      else act = ACT_SPARE;
    end else begin
      if (r < 45) act = ACT_DELETE;
      else if (r < 65) act = ACT_SEARCH;
      else if (r < 80) act = ACT_READ;
      else if (r < 95) act = ACT_ACT_PICK(r);
      else act = ACT_SPARE;
    end

    // Mostly legal positions; the rest is noise over the whole 5-bit field.
    if (shadow_count > 0 && $urandom_range(99) < 85) pos = POS_W'($urandom_range(1, shadow_count));
    else pos = POS_W'($urandom_range(31));

    // Searches mostly hit a stored value; small values breed duplicates.
    if (act == ACT_SEARCH && shadow_count > 0 && $urandom_range(99) < 70)
      val = shadow_cells[$urandom_range(shadow_count - 1)];
    else if ($urandom_range(99) < 20) val = $urandom_range(3);
    else val = $urandom;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: the block cannot be held off, so take every strobed word and
  // compare it against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: status %0h element %0h",
               out_status, out_element);
        fail_count++;
      end else begin
        seen_word = expected_words.pop_front();
        check_field("status", seen_word.status, out_status);
        check_field("found_position", seen_word.found_position, out_found_position);
        check_field("element", seen_word.element, out_element);
        check_field("length", seen_word.length, out_length);
        check_field("last", seen_word.last, out_last);
      end
    end
  end

  // Watchdog: count cycles where no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [ACT_W-1:0]         act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       idle_pct [3];

    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = ACT_HEAD;
    in_position  = '0;
    in_value     = '0;
    fail_count   = 0;
    quiet_cycles = 0;
    shadow_count = 0;
    draining     = 1'b0;
    idle_pct     = '{0, 50, 21};

    // Directed plan. The list after each row is noted where it matters.
    plan = '{
      // empty list: readout, delete, search, positional inserts all refuse
      '{ACT_READ,   5'd0,  32'sd0,         5'd1,  1'b1, STAT_EMPTY,  5'd0, 5'd0},
      '{ACT_DELETE, 5'd1,  32'sd0,         5'd1,  1'b1, STAT_EMPTY,  5'd0, 5'd0},
      '{ACT_SEARCH, 5'd0,  32'sd0,         5'd1,  1'b1, STAT_EMPTY,  5'd0, 5'd0},
      '{ACT_BEFORE, 5'd1,  32'sd5,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd0},
      '{ACT_AFTER,  5'd0,  32'sd5,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd0},
      // append to an empty list, then extremes: [min, max]
      '{ACT_TAIL,   5'd0,  32'h7fffffff,   5'd1,  1'b1, STAT_OK,     5'd0, 5'd1},
      '{ACT_HEAD,   5'd31, 32'h80000000,   5'd1,  1'b1, STAT_OK,     5'd0, 5'd2},
      // insert before the head becomes the head: [1, min, max]
      '{ACT_BEFORE, 5'd1,  32'sd1,         5'd1,  1'b1, STAT_OK,     5'd0, 5'd3},
      // insert after the tail: [1, min, max, -1]
      '{ACT_AFTER,  5'd3,  32'hffffffff,   5'd1,  1'b1, STAT_OK,     5'd0, 5'd4},
      '{ACT_BEFORE, 5'd5,  32'sd7,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd4},
      '{ACT_AFTER,  5'd31, 32'sd7,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd4},
      '{ACT_SEARCH, 5'd0,  32'hffffffff,   5'd1,  1'b1, STAT_OK,     5'd4, 5'd4},
      '{ACT_SEARCH, 5'd0,  32'sd2,         5'd1,  1'b1, STAT_EMPTY,  5'd0, 5'd4},
      '{ACT_SPARE,  5'd9,  32'h12345678,   5'd1,  1'b1, STAT_OK,     5'd0, 5'd4},
      '{ACT_DELETE, 5'd0,  32'sd0,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd4},
      '{ACT_DELETE, 5'd5,  32'sd0,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd4},
      '{ACT_READ,   5'd0,  32'sd0,         5'd1,  1'b0, STAT_OK,     5'd0, 5'd0},
      // drop min: [1, max, -1]
      '{ACT_DELETE, 5'd2,  32'sd0,         5'd1,  1'b1, STAT_OK,     5'd0, 5'd3},
      // fill up with a repeated value to sixteen entries
      '{ACT_TAIL,   5'd0,  32'h5a5a5a5a,   5'd13, 1'b0, STAT_OK,     5'd0, 5'd0},
      // full list refuses every insert, ahead of any position check
      '{ACT_HEAD,   5'd0,  32'sd3,         5'd1,  1'b1, STAT_FULL,   5'd0, 5'd16},
      '{ACT_TAIL,   5'd0,  32'sd3,         5'd1,  1'b1, STAT_FULL,   5'd0, 5'd16},
      '{ACT_BEFORE, 5'd0,  32'sd3,         5'd1,  1'b1, STAT_FULL,   5'd0, 5'd16},
      '{ACT_AFTER,  5'd16, 32'sd3,         5'd1,  1'b1, STAT_FULL,   5'd0, 5'd16},
      '{ACT_READ,   5'd0,  32'sd0,         5'd1,  1'b0, STAT_OK,     5'd0, 5'd0},
      // duplicates: the first match wins
      '{ACT_SEARCH, 5'd0,  32'h5a5a5a5a,   5'd1,  1'b1, STAT_OK,     5'd4, 5'd16},
      '{ACT_DELETE, 5'd16, 32'sd0,         5'd1,  1'b1, STAT_OK,     5'd0, 5'd15},
      '{ACT_DELETE, 5'd16, 32'sd0,         5'd1,  1'b1, STAT_BADPOS, 5'd0, 5'd15}
    };

    // Hold reset, then release it away from the active edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed plan; typed rows replace the predicted word with their own.
    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        issue_word(plan[r].act, plan[r].pos, plan[r].val, 0);
        if (plan[r].typed) begin
          void'(expected_words.pop_back());
          expected_words.push_back(list_word_t'{plan[r].status, plan[r].found_position, '0,
                                                plan[r].length, 1'b1});
        end
      end
    end

    // Random words in phases: no idling, heavy sender idling, light sender idling.
    foreach (idle_pct[p]) begin
      for (int k = 0; k < RANDOM_WORDS; k++) begin
        pick_random_word(act, pos, val);
        issue_word(act, pos, val, idle_pct[p]);
      end
    end
    start = 1'b0;

    // Drain: wait out every expected word, then a few more cycles for strays.
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### positional_list_engine_unit.f
hdl/ple_pkg.sv
hdl/ple_cell.sv
hdl/positional_list_engine_unit.sv
test/positional_list_engine_unit_test.sv
